>>> sv/cat_pkg.sv
// Package for the countdown alarm table: transfer payload types, action and status codes,
// and the default sizes.
// It has no dependencies. The alarm table core imports it; cat_ram does not.
package cat_pkg;

  localparam int CAT_SLOTS    = 16;
  localparam int CAT_TAG_BITS = 8;

  localparam int ACTION_W = 2;
  localparam int COUNT_W  = 16;
  localparam int TAG_W    = 8;
  localparam int STATUS_W = 3;

  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FINISH  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd3;

  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXPIRED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_APPLIED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [COUNT_W-1:0]  frame_count;
    logic [TAG_W-1:0]    alarm_tag;
  } cat_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    expired_tag;
    logic                last;
  } cat_out_t;

endpackage

>>> sv/cat_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// It has no dependencies. The alarm table core uses it for its entry store.
module cat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/countdown_alarm_table.sv
// Top level of the countdown alarm table: the sequencer, the entry RAM and the result register.
// It depends on cat_pkg and on cat_ram.

// Countdown alarm table. An add writes its entry when taken, unless the table is full, and
// its result is loaded into the output register from the emit state. Finish and restart read
// the entries oldest first until the tag matches. A tick reads every occupied entry newest
// first. Each entry is read through the single RAM read port, then checked in an evaluate state.
// Waiting for out_ready can stall the emit state and a tick's evaluate state. A new item
// is taken only once the previous one has placed its final result in the output register.
// Entries are kept in a circular store, and a tick writes survivors back compacted towards
// the newest end. No clearing pass is needed after reset.
module countdown_alarm_table_core #(
  parameter int SLOTS    = cat_pkg::CAT_SLOTS,
  parameter int TAG_BITS = cat_pkg::CAT_TAG_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cat_pkg::cat_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cat_pkg::cat_out_t out_data
);
  import cat_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int TW    = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int MW    = TW + 2 * COUNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TRD  = 3'd1;
  localparam logic [2:0] S_TEV  = 3'd2;
  localparam logic [2:0] S_TEND = 3'd3;
  localparam logic [2:0] S_FRD  = 3'd4;
  localparam logic [2:0] S_FEV  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W:0] b);
    logic [IDX_W+1:0] s;
    s = (IDX_W+2)'(a) + (IDX_W+2)'(b);
    if (s >= (IDX_W+2)'(SLOTS)) begin
      s = s - (IDX_W+2)'(SLOTS);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(SLOTS - 1) : p - 1'b1;
  endfunction

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [IDX_W-1:0]    rp_r, rp_nxt;
  logic [IDX_W-1:0]    wp_r, wp_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [TW-1:0]       pend_tag_r, pend_tag_nxt;
  logic [TW-1:0]       tag_r, tag_nxt;
  logic                finish_r, finish_nxt;
  cat_out_t            res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  cat_out_t            out_r, out_nxt;

  logic                out_free, out_load;
  logic                in_fire;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [MW-1:0]       ram_wdata;
  logic [MW-1:0]       ram_rdata;
  logic [TW-1:0]       rd_tag;
  logic [COUNT_W-1:0]  rd_reload, rd_remain;
  logic [TW-1:0]       in_tag;
  logic [IDX_W-1:0]    phys_used, phys_last;
  logic                rd_expire;

  cat_ram #(
    .WIDTH(MW),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rp_r),
    .rdata(ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rd_tag    = ram_rdata[MW-1 -: TW];
  assign rd_reload = ram_rdata[2*COUNT_W-1 -: COUNT_W];
  assign rd_remain = ram_rdata[COUNT_W-1:0];
  // A stored count is never negative, so reaching zero or less means it was 0 or 1.
  assign rd_expire = (rd_remain <= COUNT_W'(1));
  assign in_tag    = in_data.alarm_tag[TW-1:0];

  assign phys_used = wrap_add(head_r, (IDX_W+1)'(used_r));
  assign phys_last = wrap_add(head_r, (IDX_W+1)'(used_r - 1'b1));

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    pend_v_nxt   = pend_v_r;
    pend_tag_nxt = pend_tag_r;
    tag_nxt      = tag_r;
    finish_nxt   = finish_r;
    res_nxt      = res_r;
    out_load     = 1'b0;
    out_nxt      = res_r;
    ram_we       = 1'b0;
    ram_waddr    = wp_r;
    ram_wdata    = ram_rdata;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          tag_nxt    = in_tag;
          finish_nxt = (in_data.action == ACT_FINISH);
          res_nxt    = '{status: ST_NONE, expired_tag: '0, last: 1'b1};
          case (in_data.action)
            ACT_TICK: begin
              if (used_r == '0) begin
                state_nxt = S_EMIT;
              end else begin
                rp_nxt     = phys_last;
                wp_nxt     = phys_last;
                cnt_nxt    = used_r;
                pend_v_nxt = 1'b0;
                state_nxt  = S_TRD;
              end
            end
            ACT_ADD: begin
              if (used_r == CNT_W'(SLOTS)) begin
                res_nxt.status = ST_FULL;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = phys_used;
                ram_wdata      = {in_tag, in_data.frame_count, in_data.frame_count};
                used_nxt       = used_r + 1'b1;
                res_nxt.status = ST_ADDED;
              end
              state_nxt = S_EMIT;
            end
            default: begin
              if (used_r == '0) begin
                res_nxt.status = ST_NOTFOUND;
                state_nxt      = S_EMIT;
              end else begin
                rp_nxt    = head_r;
                cnt_nxt   = used_r;
                state_nxt = S_FRD;
              end
            end
          endcase
        end
      end
      S_TRD: begin
        state_nxt = S_TEV;
      end
      S_TEV: begin
        // An expiry is held back until the next one is found, so that the final
        // result of the tick can carry last.
        if (!(rd_expire && pend_v_r && !out_free)) begin
          if (rd_expire) begin
            if (pend_v_r) begin
              out_load = 1'b1;
              out_nxt  = '{status: ST_EXPIRED, expired_tag: TAG_W'(pend_tag_r), last: 1'b0};
            end
            pend_v_nxt   = 1'b1;
            pend_tag_nxt = rd_tag;
            used_nxt     = used_r - 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wp_r;
            ram_wdata = {rd_tag, rd_reload, rd_remain - 1'b1};
            wp_nxt    = ptr_dec(wp_r);
          end
          cnt_nxt   = cnt_r - 1'b1;
          rp_nxt    = ptr_dec(rp_r);
          state_nxt = (cnt_r == CNT_W'(1)) ? S_TEND : S_TRD;
        end
      end
      S_TEND: begin
        // Survivors now sit just above the write pointer.
        head_nxt = ptr_inc(wp_r);
        if (pend_v_r) begin
          res_nxt = '{status: ST_EXPIRED, expired_tag: TAG_W'(pend_tag_r), last: 1'b1};
        end else begin
          res_nxt = '{status: ST_NONE, expired_tag: '0, last: 1'b1};
        end
        state_nxt = S_EMIT;
      end
      S_FRD: begin
        state_nxt = S_FEV;
      end
      S_FEV: begin
        if (rd_tag == tag_r) begin
          ram_we         = 1'b1;
          ram_waddr      = rp_r;
          ram_wdata      = {rd_tag, rd_reload, finish_r ? COUNT_W'(0) : rd_reload};
          res_nxt.status = ST_APPLIED;
          state_nxt      = S_EMIT;
        end else if (cnt_r == CNT_W'(1)) begin
          res_nxt.status = ST_NOTFOUND;
          state_nxt      = S_EMIT;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          rp_nxt    = ptr_inc(rp_r);
          state_nxt = S_FRD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_nxt   = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      head_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      head_r      <= head_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    rp_r       <= rp_nxt;
    wp_r       <= wp_nxt;
    pend_tag_r <= pend_tag_nxt;
    tag_r      <= tag_nxt;
    finish_r   <= finish_nxt;
    res_r      <= res_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(SLOTS))
    else $error("entry count exceeds table size");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("new item taken while previous one is in progress");

  a_last_only_expired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_EXPIRED |-> out_data.last)
    else $error("non-expiry result without last");

  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_EXPIRED |-> out_data.expired_tag == '0)
    else $error("tag set on a result that is not an expiry");

endmodule
